>>> rtl/indexed_pixel_row_packer_top_assert.svh
// assertion macros used by the checker file
`ifndef INDEXED_PIXEL_ROW_PACKER_TOP_ASSERT_SVH
`define INDEXED_PIXEL_ROW_PACKER_TOP_ASSERT_SVH

// concurrent assertion on a given clock, disabled while reset is low
`define IPP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// same, on the block's own clock and reset
`define IPP_ASSERT_CLK(lbl, prop, msg) `IPP_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/ipp_pkg.sv
package ipp_pkg;

  // fixed field widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COLOR_W     = 16;
  localparam int unsigned ROW_WIDTH_W = 13;
  localparam int unsigned CFG_IDX_W   = 2;

  // default longest row in pixels
  localparam int unsigned DEF_MAX_ROW_WIDTH = 4096;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH     = 2'd0,
    REG_ROW_WIDTH = 2'd1
  } cfg_reg_e;

  // bits per pixel codes
  typedef enum logic [1:0] {
    DEPTH_1BPP = 2'd0,
    DEPTH_2BPP = 2'd1,
    DEPTH_4BPP = 2'd2,
    DEPTH_8BPP = 2'd3
  } depth_e;

  localparam depth_e DEPTH_RESET = DEPTH_8BPP;

  // status of one packing step
  typedef struct packed {
    logic emit;
    logic last;
  } pack_stat_t;

endpackage

>>> rtl/indexed_pixel_row_packer_top.sv
// Indexed pixel row packer. Each request carries one colour index; its low
// 1, 2, 4 or 8 bits (depth register) are packed into bytes, first pixel in
// the top bits, and a byte leaves when it is full or when the last pixel of a
// row (row width register, 0 read as 1, saturated at MAX_ROW_WIDTH) arrives;
// a row's last byte is zero padded and carries row_end_o. One request is taken
// every cycle unless in_stall_o is high: a pixel passes an input register and
// then a result register, each holding one item, and in_stall_o rises only while
// the result register is full and stalled. Registers are written through the
// config port, which is always ready; the user must write them only while no
// pixel is in flight, and the block itself does not enforce this.
module indexed_pixel_row_packer_top
  import ipp_pkg::*;
#(
  parameter int unsigned MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ROW_WIDTH_W-1:0] cfg_data_i,
  // pixel input
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [COLOR_W-1:0]     color_index_i,
  // byte output
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [BYTE_W-1:0]      packed_byte_o,
  output logic                   row_end_o
);

  localparam int unsigned COL_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int unsigned CMP_W = (COL_W + 1 > ROW_WIDTH_W) ? COL_W + 1 : ROW_WIDTH_W;
  localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_ROW_WIDTH);

  depth_e              depth_q;
  logic [CMP_W-1:0]    eff_width_q;
  logic [CMP_W-1:0]    eff_width_d;
  logic [CMP_W-1:0]    cfg_width;
  logic [BYTE_W-1:0]   partial_q;
  logic [BYTE_W-1:0]   partial_d;
  logic [COL_W-1:0]    column_q;
  logic [COL_W-1:0]    column_d;
  logic                s1_valid_q;
  logic [COLOR_W-1:0]  s1_color_q;
  logic                s1_adv;
  logic                in_accept;
  logic                out_valid_q;
  logic [BYTE_W-1:0]   out_byte_q;
  logic                out_row_end_q;
  logic [BYTE_W-1:0]   byte_d;
  pack_stat_t          stat;

  // config port never blocks
  assign cfg_ready_o = 1'b1;

  // clamp the written row width once, at write time
  assign cfg_width = CMP_W'(cfg_data_i);
  always_comb begin
    eff_width_d = cfg_width;
    if (cfg_width == '0) begin
      eff_width_d = CMP_W'(1);
    end else if (cfg_width > MAX_W) begin
      eff_width_d = MAX_W;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= DEPTH_RESET;
      eff_width_q <= CMP_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_DEPTH:     depth_q     <= depth_e'(cfg_data_i[1:0]);
        REG_ROW_WIDTH: eff_width_q <= eff_width_d;
        default: ;
      endcase
    end
  end

  // handshake: stage one moves on when the result register is free
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  // packing datapath
  ipp_pack #(
    .COL_W (COL_W),
    .CMP_W (CMP_W)
  ) u_pack (
    .depth_i       (depth_q),
    .column_i      (column_q),
    .eff_width_i   (eff_width_q),
    .partial_i     (partial_q),
    .color_index_i (s1_color_q),
    .partial_o     (partial_d),
    .column_o      (column_d),
    .byte_o        (byte_d),
    .stat_o        (stat)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      partial_q   <= '0;
      column_q    <= '0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q && stat.emit;
      end
      if (s1_valid_q && s1_adv) begin
        partial_q <= partial_d;
        column_q  <= column_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_color_q <= color_index_i;
    end
    if (s1_valid_q && s1_adv && stat.emit) begin
      out_byte_q    <= byte_d;
      out_row_end_q <= stat.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packed_byte_o = out_byte_q;
  assign row_end_o     = out_row_end_q;

endmodule

>>> rtl/ipp_pack.sv
module ipp_pack
  import ipp_pkg::*;
#(
  parameter int unsigned COL_W = 12,
  parameter int unsigned CMP_W = 13
) (
  input  depth_e             depth_i,
  input  logic [COL_W-1:0]   column_i,
  input  logic [CMP_W-1:0]   eff_width_i,
  input  logic [BYTE_W-1:0]  partial_i,
  input  logic [COLOR_W-1:0] color_index_i,
  output logic [BYTE_W-1:0]  partial_o,
  output logic [COL_W-1:0]   column_o,
  output logic [BYTE_W-1:0]  byte_o,
  output pack_stat_t         stat_o
);

  logic [CMP_W-1:0]  col_ext;
  logic [CMP_W-1:0]  col_inc;
  logic [2:0]        slot;
  logic [2:0]        shift;
  logic [BYTE_W-1:0] pix;
  logic [BYTE_W-1:0] merged;
  logic              full;
  logic              last;

  assign col_ext = CMP_W'(column_i);
  assign col_inc = col_ext + CMP_W'(1);
  assign slot    = col_ext[2:0];

  // pixel mask, slot position and byte-full flag per depth
  always_comb begin
    case (depth_i)
      DEPTH_1BPP: begin
        pix   = {7'd0, color_index_i[0]};
        shift = 3'd7 - slot;
        full  = (slot == 3'd7);
      end
      DEPTH_2BPP: begin
        pix   = {6'd0, color_index_i[1:0]};
        shift = 3'd6 - {slot[1:0], 1'b0};
        full  = (slot[1:0] == 2'd3);
      end
      DEPTH_4BPP: begin
        pix   = {4'd0, color_index_i[3:0]};
        shift = slot[0] ? 3'd0 : 3'd4;
        full  = slot[0];
      end
      default: begin
        pix   = color_index_i[BYTE_W-1:0];
        shift = 3'd0;
        full  = 1'b1;
      end
    endcase
  end

  // merge pixel, detect row end, advance column
  assign merged      = partial_i | (pix << shift);
  assign last        = (col_inc >= eff_width_i);
  assign stat_o.last = last;
  assign stat_o.emit = last | full;
  assign byte_o      = merged;
  assign partial_o   = (last | full) ? '0 : merged;
  assign column_o    = last ? '0 : column_i + COL_W'(1);

endmodule

>>> rtl/ipp_checker.sv
`include "indexed_pixel_row_packer_top_assert.svh"

module ipp_checker
  import ipp_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [BYTE_W-1:0]      packed_byte_o,
  input logic                   row_end_o
);

  logic            in_accept;
  logic            out_held;
  logic [BYTE_W:0] out_word;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_held  = out_valid_o && out_stall_i;
  assign out_word  = {packed_byte_o, row_end_o};

  // input backs up only behind a full, stalled result
  `IPP_ASSERT_CLK(a_stall_full, in_stall_o |-> out_valid_o && out_stall_i, "in stall, out free")

  // a byte that appears must be preceded by an accepted request
  `IPP_ASSERT_CLK(a_out_latency, $rose(out_valid_o) |-> $past(in_accept, 2), "orphan byte")

  // a stalled result holds
  `IPP_ASSERT_CLK(a_out_hold, out_held |=> out_valid_o && $stable(out_word), "byte changed")

endmodule

bind indexed_pixel_row_packer_top ipp_checker u_ipp_checker (.*);
